// ===== design/x86e_pkg.sv =====
package x86e_pkg;

  localparam int MaxBytes = 8;
  localparam int CntW = 4;

  typedef logic [MaxBytes-1:0][7:0] code_t;

  typedef enum logic [5:0] {
    CmdMovRR, CmdMovRI, CmdLoad, CmdStore, CmdLoadSz, CmdStoreSz, CmdLea,
    CmdAddRR, CmdSubRR, CmdXorRR, CmdAndRR, CmdOrRR, CmdCmpRR, CmdTestRR,
    CmdAddRI, CmdOrRI, CmdAndRI, CmdSubRI, CmdXorRI, CmdCmpRI,
    CmdShlI, CmdShrI, CmdSarI, CmdRolI, CmdRorI,
    CmdShlCl, CmdShrCl, CmdSarCl, CmdRolCl, CmdRorCl,
    CmdInc, CmdDec, CmdNeg, CmdNot, CmdBswap, CmdPush, CmdPop, CmdPushImm,
    CmdPushfd, CmdPopfd, CmdRet, CmdCallR, CmdJmpR, CmdCallRel, CmdJmpRel,
    CmdJmpMem, CmdJccRel, CmdJmpRel8, CmdJccRel8, CmdMovzx8, CmdMovzx16,
    CmdMovsx8, CmdMovsx16, CmdMovsxd, CmdSegLoad, CmdNop, CmdInt3, CmdLoadNoIdx
  } cmd_t;

  typedef struct packed {
    logic [5:0]  command;
    logic [3:0]  reg_a;
    logic [3:0]  reg_b;
    logic [3:0]  base_reg;
    logic [3:0]  index_reg;
    logic [1:0]  sib_scale;
    logic [31:0] displacement;
    logic [31:0] immediate;
    logic [3:0]  condition;
    logic [1:0]  access_size;
    logic        load_signed;
    logic [1:0]  segment;
  } req_t;

  // decoded request, registered between decode and assembly
  typedef struct packed {
    logic        drop;
    logic        err;
    logic [2:0]  hcnt;
    logic [3:0][7:0] head;
    logic        use_mem;
    logic [2:0]  rf;
    logic [3:0]  base;
    logic [3:0]  index;
    logic [1:0]  scale;
    logic        tail4;
    logic [31:0] tail;
  } dec_t;

  typedef struct packed {
    logic        drop;
    logic        err;
    code_t       bytes;
    logic [CntW-1:0] cnt;
  } enc_t;

  localparam logic [7:0] OpAluImm  = 8'h81;
  localparam logic [7:0] OpShImm   = 8'hC1;
  localparam logic [7:0] OpShCl    = 8'hD3;
  localparam logic [7:0] OpMovLoad = 8'h8B;
  localparam logic [7:0] OpMovSt   = 8'h89;
  localparam logic [7:0] OpEsc     = 8'h0F;
  localparam logic [7:0] OpOpSize  = 8'h66;
  localparam logic [7:0] OpMovSt8  = 8'h88;
  localparam logic [7:0] OpLea     = 8'h8D;
  localparam logic [7:0] OpMovImm  = 8'hB8;
  localparam logic [7:0] SibEsp    = 8'h24;
  localparam logic [7:0] OpJmpRel  = 8'hE9;

  localparam logic [7:0] OpAddRR   = 8'h01;
  localparam logic [7:0] OpSubRR   = 8'h29;
  localparam logic [7:0] OpXorRR   = 8'h31;
  localparam logic [7:0] OpAndRR   = 8'h21;
  localparam logic [7:0] OpOrRR    = 8'h09;
  localparam logic [7:0] OpCmpRR   = 8'h39;
  localparam logic [7:0] OpTestRR  = 8'h85;
  localparam logic [7:0] OpGrpFF   = 8'hFF;
  localparam logic [7:0] OpGrpF7   = 8'hF7;
  localparam logic [7:0] OpBswap   = 8'hC8;
  localparam logic [7:0] OpPush    = 8'h50;
  localparam logic [7:0] OpPop     = 8'h58;
  localparam logic [7:0] OpPushImm = 8'h68;
  localparam logic [7:0] OpPushfd  = 8'h9C;
  localparam logic [7:0] OpPopfd   = 8'h9D;
  localparam logic [7:0] OpRet     = 8'hC3;
  localparam logic [7:0] OpCallRel = 8'hE8;
  localparam logic [7:0] OpJmpRel8 = 8'hEB;
  localparam logic [7:0] OpJccRel8 = 8'h70;
  localparam logic [7:0] OpJccRel  = 8'h80;
  localparam logic [7:0] OpNop     = 8'h90;
  localparam logic [7:0] OpInt3    = 8'hCC;
  localparam logic [7:0] OpMovzx8  = 8'hB6;
  localparam logic [7:0] OpMovzx16 = 8'hB7;
  localparam logic [7:0] OpMovsx8  = 8'hBE;
  localparam logic [7:0] OpMovsx16 = 8'hBF;
  localparam logic [7:0] PfxFs     = 8'h64;
  localparam logic [7:0] PfxGs     = 8'h65;

  localparam logic [2:0] RegEsp = 3'd4;
  localparam logic [2:0] RmDisp = 3'd5;
  localparam logic [3:0] NoReg  = 4'd8;

  function automatic logic [7:0] modrm(input logic [1:0] md, input logic [2:0] rg,
                                       input logic [2:0] rm);
    modrm = {md, rg, rm};
  endfunction

endpackage

// ===== design/x86e_decode.sv =====
module x86e_decode (
  input  x86e_pkg::req_t r,
  output x86e_pkg::dec_t d
);
  import x86e_pkg::*;

  logic [5:0] c;
  logic ua, ub, ubase, uidx;
  logic [2:0] ra, rb;
  logic [7:0] alu_rr, ext_op;
  logic [2:0] ext3;

  always_comb begin
    c = r.command;
    ra = r.reg_a[2:0];
    rb = r.reg_b[2:0];
    ua = c inside {[CmdMovRR:CmdLoad], CmdLoadSz, [CmdLea:CmdPop], CmdCallR, CmdJmpR,
                   [CmdMovzx8:CmdSegLoad], CmdLoadNoIdx};
    ub = c inside {CmdMovRR, CmdStore, CmdStoreSz, [CmdAddRR:CmdTestRR],
                   [CmdMovzx8:CmdMovsxd]};
    ubase = c inside {[CmdLoad:CmdLea], CmdLoadNoIdx};
    uidx = c inside {CmdLoad, CmdStore, CmdLea};
    case (c)
      CmdAddRR: alu_rr = OpAddRR;
      CmdSubRR: alu_rr = OpSubRR;
      CmdXorRR: alu_rr = OpXorRR;
      CmdAndRR: alu_rr = OpAndRR;
      CmdOrRR:  alu_rr = OpOrRR;
      CmdCmpRR: alu_rr = OpCmpRR;
      default:  alu_rr = OpTestRR;
    endcase
    case (c)
      CmdAddRI: ext3 = 3'd0;
      CmdOrRI:  ext3 = 3'd1;
      CmdAndRI: ext3 = 3'd4;
      CmdSubRI: ext3 = 3'd5;
      CmdXorRI: ext3 = 3'd6;
      CmdCmpRI: ext3 = 3'd7;
      CmdShlI, CmdShlCl: ext3 = 3'd4;
      CmdShrI, CmdShrCl: ext3 = 3'd5;
      CmdSarI, CmdSarCl: ext3 = 3'd7;
      CmdRolI, CmdRolCl: ext3 = 3'd0;
      default: ext3 = 3'd1;
    endcase
    case (c)
      CmdMovzx8:  ext_op = OpMovzx8;
      CmdMovzx16: ext_op = OpMovzx16;
      CmdMovsx8:  ext_op = OpMovsx8;
      default:    ext_op = OpMovsx16;
    endcase

    d = '0;
    d.drop = c > CmdLoadNoIdx;
    d.err = (ua && r.reg_a[3]) || (ub && r.reg_b[3]) || (ubase && r.base_reg > NoReg)
            || (uidx && r.index_reg > NoReg) || (c == CmdJmpMem && r.base_reg[3]);
    d.base = r.base_reg;
    d.index = NoReg;
    d.scale = r.sib_scale;
    d.tail = r.displacement;
    d.rf = ra;
    case (c)
      CmdMovRR, CmdMovsxd: begin
        d.head[0] = OpMovSt; d.head[1] = modrm(2'd3, rb, ra); d.hcnt = 3'd2;
      end
      CmdMovRI: begin
        d.head[0] = OpMovImm + {5'd0, ra}; d.hcnt = 3'd1;
        d.tail4 = 1'b1; d.tail = r.immediate;
      end
      CmdLoad, CmdLea, CmdLoadNoIdx: begin
        d.head[0] = (c == CmdLea) ? OpLea : OpMovLoad; d.hcnt = 3'd1; d.use_mem = 1'b1;
        if (c != CmdLoadNoIdx) d.index = r.index_reg;
        else d.scale = 2'd0;
      end
      CmdStore: begin
        d.head[0] = OpMovSt; d.hcnt = 3'd1; d.use_mem = 1'b1; d.rf = rb;
        d.index = r.index_reg;
      end
      CmdLoadSz: begin
        d.use_mem = 1'b1; d.scale = 2'd0;
        if (r.access_size[1]) begin
          d.head[0] = OpMovLoad; d.hcnt = 3'd1;
        end else begin
          d.head[0] = OpEsc; d.hcnt = 3'd2;
          if (r.access_size[0]) d.head[1] = r.load_signed ? OpMovsx16 : OpMovzx16;
          else d.head[1] = r.load_signed ? OpMovsx8 : OpMovzx8;
        end
      end
      CmdStoreSz: begin
        d.use_mem = 1'b1; d.scale = 2'd0; d.rf = rb;
        if (r.access_size[1]) begin
          d.head[0] = OpMovSt; d.hcnt = 3'd1;
        end else if (r.access_size[0]) begin
          d.head[0] = OpOpSize; d.head[1] = OpMovSt; d.hcnt = 3'd2;
        end else begin
          d.head[0] = OpMovSt8; d.hcnt = 3'd1;
        end
      end
      CmdAddRR, CmdSubRR, CmdXorRR, CmdAndRR, CmdOrRR, CmdCmpRR, CmdTestRR: begin
        d.head[0] = alu_rr; d.head[1] = modrm(2'd3, rb, ra); d.hcnt = 3'd2;
      end
      CmdAddRI, CmdOrRI, CmdAndRI, CmdSubRI, CmdXorRI, CmdCmpRI: begin
        d.head[0] = OpAluImm; d.head[1] = modrm(2'd3, ext3, ra); d.hcnt = 3'd2;
        d.tail4 = 1'b1; d.tail = r.immediate;
      end
      CmdShlI, CmdShrI, CmdSarI, CmdRolI, CmdRorI: begin
        d.head[0] = OpShImm; d.head[1] = modrm(2'd3, ext3, ra);
        d.head[2] = r.immediate[7:0]; d.hcnt = 3'd3;
      end
      CmdShlCl, CmdShrCl, CmdSarCl, CmdRolCl, CmdRorCl: begin
        d.head[0] = OpShCl; d.head[1] = modrm(2'd3, ext3, ra); d.hcnt = 3'd2;
      end
      CmdInc, CmdDec: begin
        d.head[0] = OpGrpFF; d.head[1] = modrm(2'd3, (c == CmdDec) ? 3'd1 : 3'd0, ra);
        d.hcnt = 3'd2;
      end
      CmdNeg, CmdNot: begin
        d.head[0] = OpGrpF7; d.head[1] = modrm(2'd3, (c == CmdNeg) ? 3'd3 : 3'd2, ra);
        d.hcnt = 3'd2;
      end
      CmdBswap: begin
        d.head[0] = OpEsc; d.head[1] = OpBswap + {5'd0, ra}; d.hcnt = 3'd2;
      end
      CmdPush: begin d.head[0] = OpPush + {5'd0, ra}; d.hcnt = 3'd1; end
      CmdPop: begin d.head[0] = OpPop + {5'd0, ra}; d.hcnt = 3'd1; end
      CmdPushImm: begin
        d.head[0] = OpPushImm; d.hcnt = 3'd1; d.tail4 = 1'b1; d.tail = r.immediate;
      end
      CmdPushfd: begin d.head[0] = OpPushfd; d.hcnt = 3'd1; end
      CmdPopfd: begin d.head[0] = OpPopfd; d.hcnt = 3'd1; end
      CmdRet: begin d.head[0] = OpRet; d.hcnt = 3'd1; end
      CmdCallR: begin
        d.head[0] = OpGrpFF; d.head[1] = modrm(2'd3, 3'd2, ra); d.hcnt = 3'd2;
      end
      CmdJmpR: begin
        d.head[0] = OpGrpFF; d.head[1] = modrm(2'd3, 3'd4, ra); d.hcnt = 3'd2;
      end
      CmdCallRel, CmdJmpRel: begin
        d.head[0] = (c == CmdCallRel) ? OpCallRel : OpJmpRel; d.hcnt = 3'd1;
        d.tail4 = 1'b1;
      end
      CmdJmpMem: begin
        d.head[0] = OpGrpFF; d.head[1] = modrm(2'd2, 3'd4, r.base_reg[2:0]);
        d.head[2] = SibEsp; d.hcnt = (r.base_reg[2:0] == RegEsp) ? 3'd3 : 3'd2;
        d.tail4 = 1'b1;
      end
      CmdJccRel: begin
        d.head[0] = OpEsc; d.head[1] = OpJccRel + {4'd0, r.condition}; d.hcnt = 3'd2;
        d.tail4 = 1'b1;
      end
      CmdJmpRel8: begin
        d.head[0] = OpJmpRel8; d.head[1] = r.immediate[7:0]; d.hcnt = 3'd2;
      end
      CmdJccRel8: begin
        d.head[0] = OpJccRel8 + {4'd0, r.condition}; d.head[1] = r.immediate[7:0];
        d.hcnt = 3'd2;
      end
      CmdMovzx8, CmdMovzx16, CmdMovsx8, CmdMovsx16: begin
        d.head[0] = OpEsc; d.head[1] = ext_op; d.head[2] = modrm(2'd3, ra, rb);
        d.hcnt = 3'd3;
      end
      CmdSegLoad: begin
        if (r.segment == 2'd1 || r.segment == 2'd2) begin
          d.head[0] = r.segment[1] ? PfxGs : PfxFs; d.head[1] = OpMovLoad;
          d.head[2] = modrm(2'd0, ra, RmDisp); d.hcnt = 3'd3;
        end else begin
          d.head[0] = OpMovLoad; d.head[1] = modrm(2'd0, ra, RmDisp); d.hcnt = 3'd2;
        end
        d.tail4 = 1'b1;
      end
      CmdNop: begin d.head[0] = OpNop; d.hcnt = 3'd1; end
      default: begin d.head[0] = OpInt3; d.hcnt = 3'd1; end
    endcase
  end
endmodule

// ===== design/x86e_assemble.sv =====
module x86e_assemble (
  input  x86e_pkg::dec_t d,
  output x86e_pkg::enc_t e
);
  import x86e_pkg::*;

  logic nb, ni, sib, zero, d8;
  logic [1:0] md;
  logic [7:0] mb [3];
  logic [2:0] mcnt;
  logic [7:0] tb [4];
  logic [2:0] tcnt;
  logic [7:0] all [11];
  logic [31:0] dp;

  always_comb begin
    dp = d.tail;
    nb = d.base == 4'd8;
    ni = d.index == 4'd8;
    sib = !ni || d.base[2:0] == 3'd4;
    zero = (dp == 32'd0) && d.base[2:0] != 3'd5;
    d8 = (dp[31:7] == '0) || (dp[31:7] == '1);
    md = zero ? 2'd0 : (d8 ? 2'd1 : 2'd2);
    mb[0] = '0; mb[1] = '0; mb[2] = '0;
    mcnt = 3'd0;
    tcnt = 3'd0;
    if (d.use_mem) begin
      if (nb && ni) begin
        mb[0] = modrm(2'd0, d.rf, 3'd5); mcnt = 3'd1; tcnt = 3'd4;
      end else if (nb) begin
        mb[0] = modrm(2'd0, d.rf, 3'd4);
        mb[1] = modrm(d.scale, d.index[2:0], 3'd5); mcnt = 3'd2; tcnt = 3'd4;
      end else begin
        if (sib) begin
          mb[0] = modrm(md, d.rf, 3'd4);
          mb[1] = modrm(d.scale, ni ? 3'd4 : d.index[2:0], d.base[2:0]); mcnt = 3'd2;
        end else begin
          mb[0] = modrm(md, d.rf, d.base[2:0]); mcnt = 3'd1;
        end
        tcnt = (md == 2'd1) ? 3'd1 : ((md == 2'd2) ? 3'd4 : 3'd0);
      end
    end else if (d.tail4) begin
      tcnt = 3'd4;
    end
    for (int i = 0; i < 4; i++) tb[i] = dp[8*i +: 8];
    for (int i = 0; i < 11; i++) all[i] = '0;
    for (int i = 0; i < 4; i++) if (3'(i) < d.hcnt) all[i] = d.head[i];
    for (int i = 0; i < 3; i++)
      if (3'(i) < mcnt) all[4'(d.hcnt) + 4'(i)] = mb[i];
    for (int i = 0; i < 4; i++)
      if (3'(i) < tcnt) all[4'(d.hcnt) + 4'(mcnt) + 4'(i)] = tb[i];
    e.drop = d.drop;
    e.err = d.err;
    for (int i = 0; i < MaxBytes; i++) e.bytes[i] = all[i];
    e.cnt = CntW'(d.hcnt) + CntW'(mcnt) + CntW'(tcnt);
  end
endmodule

// ===== design/x86e_serial.sv =====
module x86e_serial (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  x86e_pkg::enc_t  e,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      code_byte,
  output logic            last,
  output logic            error
);
  import x86e_pkg::*;

  logic            busy;
  enc_t            cur;
  logic [CntW-1:0] pos;
  logic            fin;

  assign fin = cur.err || (pos + 1'b1 == cur.cnt);
  assign in_stall = busy && !(out_valid && !out_stall && fin);
  assign out_valid = busy;
  assign code_byte = cur.err ? 8'd0 : cur.bytes[pos[2:0]];
  assign last = fin;
  assign error = cur.err;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos <= '0;
    end else begin
      if (busy && !out_stall) begin
        pos <= pos + 1'b1;
        if (fin) begin
          busy <= 1'b0;
          pos <= '0;
        end
      end
      if (in_valid && !in_stall && !e.drop) begin
        busy <= 1'b1;
        pos <= '0;
      end
    end
    if (in_valid && !in_stall) cur <= e;
  end
endmodule

// ===== design/x86_32_instruction_encoder.sv =====
// channel | handshake          | payload
// in      | in_valid/in_stall  | command .. segment
// out     | out_valid/out_stall| code_byte, last, error
// Three register stages: input, decode, assembly; then a byte serialiser.
// One byte leaves per cycle while out_stall is low; an instruction gives its n bytes
// (one word for an error, none for an unused command); the serialiser sets the rate.
// rst is synchronous and clears all valid bits.
// Stalls back up through every stage; each stage holds while the next is full and stalled.
module x86_32_instruction_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  command,
  input  logic [3:0]  reg_a,
  input  logic [3:0]  reg_b,
  input  logic [3:0]  base_reg,
  input  logic [3:0]  index_reg,
  input  logic [1:0]  sib_scale,
  input  logic signed [31:0] displacement,
  input  logic signed [31:0] immediate,
  input  logic [3:0]  condition,
  input  logic [1:0]  access_size,
  input  logic        load_signed,
  input  logic [1:0]  segment,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  code_byte,
  output logic        last,
  output logic        error
);
  import x86e_pkg::*;

  logic v1, v2, v3;
  req_t r1, rin;
  dec_t d2, dn;
  enc_t e3, en;
  logic s3, adv1, adv2, adv3;

  assign adv3 = !v3 || !s3;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign in_stall = !adv1;

  assign rin = '{command, reg_a, reg_b, base_reg, index_reg, sib_scale,
                 displacement, immediate, condition, access_size, load_signed, segment};

  x86e_decode u_dec (.r(r1), .d(dn));
  x86e_assemble u_asm (.d(d2), .e(en));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
    if (adv1) r1 <= rin;
    if (adv2) d2 <= dn;
    if (adv3) e3 <= en;
  end

  x86e_serial u_ser (
    .clk, .rst, .in_valid(v3), .in_stall(s3), .e(e3),
    .out_valid, .out_stall, .code_byte, .last, .error
  );
endmodule

// ===== dv/x86_32_instruction_encoder_tb.sv =====
module x86_32_instruction_encoder_tb;
  import x86e_pkg::*;

  localparam int IdleLimit = 5000;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last;
    logic       error;
  } byte_t;

  logic clk = 1'b0, rst = 1'b1;
  logic in_valid = 1'b0, in_stall;
  req_t drv = '0;
  logic out_valid, out_stall = 1'b0;
  logic [7:0] code_byte;
  logic last, error;

  req_t  pending_q[$];
  byte_t code_q[$];
  bit    stim_done = 1'b0;
  int    fails = 0;
  int    idle_cycles = 0;

  x86_32_instruction_encoder u_dut (
    .clk, .rst, .in_valid, .in_stall,
    .command(drv.command), .reg_a(drv.reg_a), .reg_b(drv.reg_b),
    .base_reg(drv.base_reg), .index_reg(drv.index_reg), .sib_scale(drv.sib_scale),
    .displacement(drv.displacement), .immediate(drv.immediate),
    .condition(drv.condition), .access_size(drv.access_size),
    .load_signed(drv.load_signed), .segment(drv.segment),
    .out_valid, .out_stall, .code_byte, .last, .error
  );

  initial forever #5 clk = ~clk;

  function automatic logic [7:0] mrm(input logic [1:0] md, input logic [2:0] rg,
                                     input logic [2:0] rm);
    return {md, rg, rm};
  endfunction

  function automatic void add_byte(ref logic [7:0] b[$], input logic [7:0] v);
    b.insert(b.size(), v);
  endfunction

  function automatic void add_word(input byte_t w);
    code_q.insert(code_q.size(), w);
  endfunction

  function automatic void add_req(input req_t r);
    pending_q.insert(pending_q.size(), r);
  endfunction

  function automatic void push32(ref logic [7:0] b[$], input logic [31:0] v);
    for (int i = 0; i < 4; i++) add_byte(b, v[8*i +: 8]);
  endfunction

  function automatic void push_mem(ref logic [7:0] b[$], input logic [2:0] rf,
                                   input logic [3:0] base, input logic [3:0] index,
                                   input logic [1:0] scale, input logic [31:0] disp);
    logic nb, ni, sib, zero, d8;
    logic [1:0] md;
    logic [31:0] dp;
    nb = (base == NoReg);
    ni = (index == NoReg);
    dp = disp + 32'd128;
    if (nb && ni) begin
      add_byte(b, mrm(2'd0, rf, RmDisp));
      push32(b, disp);
      return;
    end
    if (nb) begin
      add_byte(b, mrm(2'd0, rf, RegEsp));
      add_byte(b, mrm(scale, index[2:0], RmDisp));
      push32(b, disp);
      return;
    end
    sib = !ni || base[2:0] == RegEsp;
    zero = (disp == 32'd0) && base[2:0] != RmDisp;
    d8 = dp < 32'd256;
    md = zero ? 2'd0 : (d8 ? 2'd1 : 2'd2);
    if (sib) begin
      add_byte(b, mrm(md, rf, RegEsp));
      add_byte(b, mrm(scale, ni ? RegEsp : index[2:0], base[2:0]));
    end else begin
      add_byte(b, mrm(md, rf, base[2:0]));
    end
    if (md == 2'd1) add_byte(b, disp[7:0]);
    else if (md == 2'd2) push32(b, disp);
  endfunction

  // machine code of one request, appended to the expected-word queue
  function automatic void encode_instr(input req_t r);
    logic [7:0] b[$];
    logic [7:0] rr_op[7] = '{OpAddRR, OpSubRR, OpXorRR, OpAndRR, OpOrRR, OpCmpRR,
                             OpTestRR};
    logic [2:0] ri_ext[6] = '{3'd0, 3'd1, 3'd4, 3'd5, 3'd6, 3'd7};
    logic [2:0] sh_ext[5] = '{3'd4, 3'd5, 3'd7, 3'd0, 3'd1};
    logic [7:0] ext_op[4] = '{OpMovzx8, OpMovzx16, OpMovsx8, OpMovsx16};
    logic ua, ub, ubase, uidx, err;
    cmd_t c;
    logic [2:0] a, s;
    c = cmd_t'(r.command);
    a = r.reg_a[2:0];
    s = r.reg_b[2:0];
    ua = c inside {[CmdMovRR:CmdMovRI], [CmdAddRI:CmdPop], CmdCallR, CmdJmpR, CmdSegLoad};
    ub = 0; ubase = 0; uidx = 0;
    if (c inside {CmdMovRR, [CmdAddRR:CmdTestRR], [CmdMovzx8:CmdMovsxd]}) begin
      ua = 1; ub = 1;
    end
    if (c == CmdLoad || c == CmdLea) begin ua = 1; ubase = 1; uidx = 1; end
    if (c == CmdStore) begin ub = 1; ubase = 1; uidx = 1; end
    if (c == CmdLoadSz || c == CmdLoadNoIdx) begin ua = 1; ubase = 1; end
    if (c == CmdStoreSz) begin ub = 1; ubase = 1; end
    err = (ua && r.reg_a > 4'd7) || (ub && r.reg_b > 4'd7) ||
          (ubase && r.base_reg > NoReg) || (uidx && r.index_reg > NoReg) ||
          (c == CmdJmpMem && r.base_reg > 4'd7);
    if (c > CmdLoadNoIdx) return;
    if (err) begin
      add_word('{8'h00, 1'b1, 1'b1});
      return;
    end
    if (c == CmdMovRR || c == CmdMovsxd) begin
      add_byte(b, OpMovSt); add_byte(b, mrm(2'd3, s, a));
    end else if (c == CmdMovRI) begin
      add_byte(b, OpMovImm + a); push32(b, r.immediate);
    end else if (c == CmdLoad) begin
      add_byte(b, OpMovLoad);
      push_mem(b, a, r.base_reg, r.index_reg, r.sib_scale, r.displacement);
    end else if (c == CmdLoadNoIdx) begin
      add_byte(b, OpMovLoad); push_mem(b, a, r.base_reg, NoReg, 2'd0, r.displacement);
    end else if (c == CmdStore) begin
      add_byte(b, OpMovSt);
      push_mem(b, s, r.base_reg, r.index_reg, r.sib_scale, r.displacement);
    end else if (c == CmdLoadSz) begin
      if (r.access_size >= 2'd2) add_byte(b, OpMovLoad);
      else begin
        add_byte(b, OpEsc);
        add_byte(b, r.access_size == 2'd1 ? (r.load_signed ? OpMovsx16 : OpMovzx16)
                                          : (r.load_signed ? OpMovsx8 : OpMovzx8));
      end
      push_mem(b, a, r.base_reg, NoReg, 2'd0, r.displacement);
    end else if (c == CmdStoreSz) begin
      if (r.access_size >= 2'd2) add_byte(b, OpMovSt);
      else if (r.access_size == 2'd1) begin
        add_byte(b, OpOpSize); add_byte(b, OpMovSt);
      end else add_byte(b, OpMovSt8);
      push_mem(b, s, r.base_reg, NoReg, 2'd0, r.displacement);
    end else if (c == CmdLea) begin
      add_byte(b, OpLea);
      push_mem(b, a, r.base_reg, r.index_reg, r.sib_scale, r.displacement);
    end else if (c <= CmdTestRR) begin
      add_byte(b, rr_op[c - CmdAddRR]); add_byte(b, mrm(2'd3, s, a));
    end else if (c <= CmdCmpRI) begin
      add_byte(b, OpAluImm); add_byte(b, mrm(2'd3, ri_ext[c - CmdAddRI], a));
      push32(b, r.immediate);
    end else if (c <= CmdRorI) begin
      add_byte(b, OpShImm); add_byte(b, mrm(2'd3, sh_ext[c - CmdShlI], a));
      add_byte(b, r.immediate[7:0]);
    end else if (c <= CmdRorCl) begin
      add_byte(b, OpShCl); add_byte(b, mrm(2'd3, sh_ext[c - CmdShlCl], a));
    end else if (c == CmdInc || c == CmdDec) begin
      add_byte(b, OpGrpFF); add_byte(b, mrm(2'd3, (c == CmdDec) ? 3'd1 : 3'd0, a));
    end else if (c == CmdNeg) begin
      add_byte(b, OpGrpF7); add_byte(b, mrm(2'd3, 3'd3, a));
    end else if (c == CmdNot) begin
      add_byte(b, OpGrpF7); add_byte(b, mrm(2'd3, 3'd2, a));
    end else if (c == CmdBswap) begin
      add_byte(b, OpEsc); add_byte(b, OpBswap + a);
    end else if (c == CmdPush) add_byte(b, OpPush + a);
    else if (c == CmdPop) add_byte(b, OpPop + a);
    else if (c == CmdPushImm) begin
      add_byte(b, OpPushImm); push32(b, r.immediate);
    end else if (c == CmdPushfd) add_byte(b, OpPushfd);
    else if (c == CmdPopfd) add_byte(b, OpPopfd);
    else if (c == CmdRet) add_byte(b, OpRet);
    else if (c == CmdCallR) begin
      add_byte(b, OpGrpFF); add_byte(b, mrm(2'd3, 3'd2, a));
    end else if (c == CmdJmpR) begin
      add_byte(b, OpGrpFF); add_byte(b, mrm(2'd3, 3'd4, a));
    end else if (c == CmdCallRel) begin
      add_byte(b, OpCallRel); push32(b, r.displacement);
    end else if (c == CmdJmpRel) begin
      add_byte(b, OpJmpRel); push32(b, r.displacement);
    end else if (c == CmdJmpMem) begin
      add_byte(b, OpGrpFF); add_byte(b, mrm(2'd2, 3'd4, r.base_reg[2:0]));
      if (r.base_reg[2:0] == RegEsp) add_byte(b, SibEsp);
      push32(b, r.displacement);
    end else if (c == CmdJccRel) begin
      add_byte(b, OpEsc); add_byte(b, OpJccRel + {4'd0, r.condition});
      push32(b, r.displacement);
    end else if (c == CmdJmpRel8) begin
      add_byte(b, OpJmpRel8); add_byte(b, r.immediate[7:0]);
    end else if (c == CmdJccRel8) begin
      add_byte(b, OpJccRel8 + {4'd0, r.condition}); add_byte(b, r.immediate[7:0]);
    end else if (c <= CmdMovsx16) begin
      add_byte(b, OpEsc); add_byte(b, ext_op[c - CmdMovzx8]); add_byte(b, mrm(2'd3, a, s));
    end else if (c == CmdSegLoad) begin
      if (r.segment == 2'd1) add_byte(b, PfxFs);
      else if (r.segment == 2'd2) add_byte(b, PfxGs);
      add_byte(b, OpMovLoad); add_byte(b, mrm(2'd0, a, RmDisp)); push32(b, r.displacement);
    end else if (c == CmdNop) add_byte(b, OpNop);
    else add_byte(b, OpInt3);
    foreach (b[k]) add_word('{b[k], k == b.size() - 1, 1'b0});
  endfunction

  function automatic logic [31:0] rand_disp();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'($urandom_range(0, 255)) - 32'd128;
      2: return 32'd127 + 32'($urandom_range(0, 1));
      3: return 32'hFFFFFF80 - 32'($urandom_range(0, 1));
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r = '0;
    r.command = ($urandom_range(0, 29) == 0) ? 6'($urandom_range(58, 63))
                                             : 6'($urandom_range(0, 57));
    r.reg_a = ($urandom_range(0, 11) == 0) ? 4'($urandom_range(8, 15))
                                           : 4'($urandom_range(0, 7));
    r.reg_b = ($urandom_range(0, 11) == 0) ? 4'($urandom_range(8, 15))
                                           : 4'($urandom_range(0, 7));
    r.base_reg = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(0, 8));
    r.index_reg = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(0, 8));
    r.sib_scale = 2'($urandom_range(0, 3));
    r.displacement = rand_disp();
    r.immediate = $urandom;
    r.condition = 4'($urandom_range(0, 15));
    r.access_size = 2'($urandom_range(0, 3));
    r.load_signed = 1'($urandom_range(0, 1));
    r.segment = 2'($urandom_range(0, 3));
    return r;
  endfunction

  function automatic req_t mk(input cmd_t c, input logic [3:0] a, input logic [3:0] b,
                              input logic [3:0] bs, input logic [3:0] ix,
                              input logic [31:0] d);
    req_t r;
    r = '0;
    r.command = c; r.reg_a = a; r.reg_b = b; r.base_reg = bs; r.index_reg = ix;
    r.displacement = d;
    r.immediate = 32'hFFFF_FF80;
    r.sib_scale = 2'd3;
    return r;
  endfunction

  initial begin
    req_t r;
    add_req(mk(CmdLoad, 4'd7, 4'd0, NoReg, NoReg, 32'h8000_0000));
    add_req(mk(CmdLea, 4'd0, 4'd0, NoReg, 4'd3, 32'd0));
    add_req(mk(CmdStore, 4'd0, 4'd6, 4'd2, 4'd4, 32'd5));
    add_req(mk(CmdLoad, 4'd1, 4'd0, 4'd5, NoReg, 32'd0));
    add_req(mk(CmdLoad, 4'd1, 4'd0, 4'd4, NoReg, 32'h7FFF_FFFF));
    add_req(mk(CmdStoreSz, 4'd0, 4'd7, 4'd3, NoReg, 32'hFFFF_FF80));
    add_req(mk(CmdMovRR, 4'd15, 4'd0, 4'd0, 4'd0, 32'd0));
    add_req(mk(CmdAddRR, 4'd0, 4'd8, 4'd0, 4'd0, 32'd0));
    add_req(mk(CmdLoad, 4'd0, 4'd0, 4'd9, NoReg, 32'd0));
    add_req(mk(CmdLea, 4'd0, 4'd0, 4'd1, 4'd15, 32'd0));
    add_req(mk(CmdJmpMem, 4'd0, 4'd0, NoReg, 4'd0, 32'd0));
    add_req(mk(CmdJmpMem, 4'd0, 4'd0, 4'd4, 4'd0, 32'hFFFF_FFFF));
    r = mk(CmdSegLoad, 4'd3, 4'd0, 4'd0, 4'd0, 32'h1234_5678);
    for (int s = 0; s < 4; s++) begin r.segment = 2'(s); add_req(r); end
    r = mk(CmdJccRel, 4'd0, 4'd0, 4'd0, 4'd0, 32'h8000_0001);
    r.condition = 4'hF; add_req(r);
    r.command = CmdJccRel8; r.condition = 4'h0; add_req(r);
    r = mk(CmdLoadSz, 4'd2, 4'd0, 4'd1, NoReg, 32'd64);
    r.access_size = 2'd1; r.load_signed = 1'b1; add_req(r);
    r.access_size = 2'd3; add_req(r);
    add_req(mk(cmd_t'(6'd63), 4'd0, 4'd0, 4'd0, 4'd0, 32'd0));
    add_req(mk(CmdLoadNoIdx, 4'd0, 4'd0, 4'd4, 4'd2, 32'd128));
    add_req(mk(CmdPushImm, 4'd0, 4'd0, 4'd0, 4'd0, 32'd0));
    for (int c = 0; c <= 57; c++)
      add_req(mk(cmd_t'(6'(c)), 4'd7, 4'd7, 4'd8, 4'd8, 32'd0));
    for (int i = 0; i < 170; i++) add_req(rand_req());
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  int burst_left = 0, gap_left = 0;

  // driver: bursts of words with random gaps
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) encode_instr(drv);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          drv <= pending_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  int stall_phase = 0;

  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    case ((stall_phase / 64) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= (stall_phase % 5) < 3;
      default: out_stall <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // monitor
  always @(posedge clk) begin
    byte_t exp_b;
    if (!rst && out_valid && !out_stall) begin
      if (code_q.size() == 0) begin
        $error("unexpected word: code_byte %h last %b error %b", code_byte, last, error);
        fails++;
      end else begin
        exp_b = code_q.pop_front();
        if (code_byte !== exp_b.code_byte) begin
          $error("code_byte expected %h actual %h", exp_b.code_byte, code_byte);
          fails++;
        end
        if (last !== exp_b.last) begin
          $error("last expected %b actual %b", exp_b.last, last);
          fails++;
        end
        if (error !== exp_b.error) begin
          $error("error expected %b actual %b", exp_b.error, error);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (!(stim_done && code_q.size() == 0) && idle_cycles < IdleLimit) @(posedge clk);
    if (idle_cycles < IdleLimit) begin
      repeat (20) @(posedge clk);
      if (fails == 0 && code_q.size() == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
